// ===== sv/boot_download_packet_framer_macros.svh =====
// Assertion macros for the boot download packet framer.
// Included by the top level; needs no other file.
`ifndef BOOT_DOWNLOAD_PACKET_FRAMER_MACROS_SVH
`define BOOT_DOWNLOAD_PACKET_FRAMER_MACROS_SVH

// Checked property, ignored while reset is high
`define BDPF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked property that also runs across reset
`define BDPF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/bdpf_pkg.sv =====
// Shared types, constants and the CRC step for the packet framer.
// No dependencies; every other file but the macro header imports it.
package bdpf_pkg;

   localparam int DATA_W      = 8;
   localparam int WORD_W      = 32;
   localparam int CRC_W       = 16;
   localparam int CHUNK_BYTES = 1024;
   localparam int CHUNK_W     = $clog2(CHUNK_BYTES + 1);
   localparam int CMD_DEPTH   = 4;
   localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);

   // APB register map, 4-byte stride
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_LOAD_MODE    = 2'd0;
   localparam logic [1:0] REG_BLOCK_SIZE   = 2'd1;
   localparam logic [1:0] REG_LOAD_ADDRESS = 2'd2;

   localparam logic [DATA_W-1:0] RESET_LOAD_MODE = 8'h01;

   // Frame marker bytes and CRC polynomial
   localparam logic [DATA_W-1:0] MARK_HEADER = 8'hFE;
   localparam logic [DATA_W-1:0] MARK_DATA   = 8'hDA;
   localparam logic [DATA_W-1:0] MARK_END    = 8'hED;
   localparam logic [CRC_W-1:0]  CRC_POLY    = 16'h1021;

   localparam logic OP_START   = 1'b0;
   localparam logic OP_PAYLOAD = 1'b1;

   // Byte counts of each output phase
   localparam int IDX_W      = 4;
   localparam int HDR_BYTES  = 12;
   localparam int OPEN_BYTES = 3;
   localparam int TRL_BYTES  = 2;

   typedef struct packed {
      logic [DATA_W-1:0] load_mode;
      logic [WORD_W-1:0] block_size;
      logic [WORD_W-1:0] load_address;
   } cfg_type;

   // One command from front to back
   typedef struct packed {
      logic              is_header;  // header frame
      logic              open;       // data frame starts with this byte
      logic              close;      // trailer follows this byte
      logic              last;       // end frame follows
      logic [DATA_W-1:0] seq;        // sequence of the data frame
      logic [DATA_W-1:0] data;
   } cmd_type;

   // CRC-16/XMODEM over one byte, MSB first
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [DATA_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < DATA_W; k++) begin
         c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

// ===== sv/bdpf_if.sv =====
// Request and response channel interfaces of the packet framer.
// Depends on bdpf_pkg.
interface bdpf_req_if import bdpf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              opcode;
   logic [DATA_W-1:0] data_byte;

   modport source (output valid, opcode, data_byte, input ready);
   modport sink   (input valid, opcode, data_byte, output ready);
endinterface

interface bdpf_rsp_if import bdpf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] out_byte;
   logic              frame_end;
   logic              block_end;

   modport source (output valid, out_byte, frame_end, block_end, input ready);
   modport sink   (input valid, out_byte, frame_end, block_end, output ready);
endinterface

// ===== sv/bdpf_csr.sv =====
// APB register block: load mode, block size, load address.
// Depends on bdpf_pkg.
module bdpf_csr import bdpf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [WORD_W-1:0]     pwdata,
   output logic [WORD_W-1:0]     prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [DATA_W-1:0] load_mode_ff;
   logic [WORD_W-1:0] block_size_ff;
   logic [WORD_W-1:0] load_address_ff;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;

   // Register writes; unmapped addresses are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         load_mode_ff    <= RESET_LOAD_MODE;
         block_size_ff   <= '0;
         load_address_ff <= '0;
      end else if (wr_en) begin
         if (reg_idx == REG_LOAD_MODE)    load_mode_ff    <= pwdata[DATA_W-1:0];
         if (reg_idx == REG_BLOCK_SIZE)   block_size_ff   <= pwdata;
         if (reg_idx == REG_LOAD_ADDRESS) load_address_ff <= pwdata;
      end
   end

   // Read mux
   always_comb begin
      unique case (reg_idx)
         REG_LOAD_MODE:    prdata = {{(WORD_W-DATA_W){1'b0}}, load_mode_ff};
         REG_BLOCK_SIZE:   prdata = block_size_ff;
         REG_LOAD_ADDRESS: prdata = load_address_ff;
         default:          prdata = '0;
      endcase
   end

   assign cfg.load_mode    = load_mode_ff;
   assign cfg.block_size   = block_size_ff;
   assign cfg.load_address = load_address_ff;

endmodule

// ===== sv/bdpf_front.sv =====
// Front end: accepts requests, tracks block and chunk state, issues commands.
// Depends on bdpf_pkg.
module bdpf_front import bdpf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_opcode,
   input  logic [DATA_W-1:0] req_data_byte,
   input  logic [WORD_W-1:0] block_size,
   input  logic              cmd_full,
   output logic              cmd_push,
   output cmd_type           cmd
);

   logic               active_ff, active_in;
   logic [DATA_W-1:0]  seq_ff, seq_in;
   logic [WORD_W-1:0]  total_ff, total_in;
   logic [CHUNK_W-1:0] chunk_ff, chunk_in;
   logic               accept;
   logic [WORD_W-1:0]  total_next;
   logic [CHUNK_W-1:0] chunk_next;
   logic               last;
   logic               close;

   assign req_ready  = !cmd_full;
   assign accept     = req_valid && req_ready;
   assign total_next = total_ff + WORD_W'(1);
   assign chunk_next = chunk_ff + CHUNK_W'(1);
   assign last       = total_next >= block_size;
   assign close      = (chunk_next >= CHUNK_W'(CHUNK_BYTES)) || last;

   // Classify the request and work out the next state
   always_comb begin
      active_in = active_ff;
      seq_in    = seq_ff;
      total_in  = total_ff;
      chunk_in  = chunk_ff;
      cmd_push  = 1'b0;
      cmd       = '0;
      cmd.data  = req_data_byte;
      cmd.seq   = seq_ff;
      if (accept) begin
         if (req_opcode == OP_START) begin
            cmd_push      = 1'b1;
            cmd.is_header = 1'b1;
            cmd.close     = 1'b1;
            cmd.last      = (block_size == '0);
            seq_in        = 8'd1;
            total_in      = '0;
            chunk_in      = '0;
            active_in     = (block_size != '0);
         end else if (active_ff) begin
            // payload while idle is dropped
            cmd_push  = 1'b1;
            cmd.open  = (chunk_ff == '0);
            cmd.close = close;
            cmd.last  = last;
            total_in  = total_next;
            chunk_in  = close ? '0 : chunk_next;
            seq_in    = close ? seq_ff + 8'd1 : seq_ff;
            active_in = !last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         seq_ff    <= 8'd1;
         total_ff  <= '0;
         chunk_ff  <= '0;
      end else begin
         active_ff <= active_in;
         seq_ff    <= seq_in;
         total_ff  <= total_in;
         chunk_ff  <= chunk_in;
      end
   end

endmodule

// ===== sv/bdpf_cmd_fifo.sv =====
// Short command queue between front and back end.
// Depends on bdpf_pkg.
module bdpf_cmd_fifo import bdpf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type              entry_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CMD_CNT_W-1:0] count_ff;
   logic                 do_push, do_pop;

   assign full       = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + CMD_PTR_W'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + CMD_PTR_W'(1);
         unique case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + CMD_CNT_W'(1);
            2'b01:   count_ff <= count_ff - CMD_CNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== sv/bdpf_back.sv =====
// Back end: expands each command into framed bytes, runs the CRC,
// and holds the response register. Depends on bdpf_pkg.
module bdpf_back import bdpf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              cmd_valid,
   input  cmd_type           cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DATA_W-1:0] rsp_out_byte,
   output logic              rsp_frame_end,
   output logic              rsp_block_end
);

   typedef enum logic [2:0] {
      PH_NEW, PH_HDR, PH_OPEN, PH_DATA, PH_TRL, PH_END, PH_ETRL
   } phase_type;

   phase_type         ph_ff, ph_in, cur_ph;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic              valid_ff, valid_in;
   logic [DATA_W-1:0] byte_ff, byte_in;
   logic              fe_ff, fe_in;
   logic              be_ff, be_in;
   logic              advance;
   logic [DATA_W-1:0] end_seq;
   logic [DATA_W-1:0] cur_byte;
   logic              covered, first, phase_done, cmd_done;
   phase_type         next_ph;

   assign advance = cmd_valid && (!valid_ff || rsp_ready);
   assign end_seq = cmd.is_header ? 8'd1 : cmd.seq + 8'd1;

   // Pick the current phase and byte
   always_comb begin
      if (ph_ff == PH_NEW)
         cur_ph = cmd.is_header ? PH_HDR : (cmd.open ? PH_OPEN : PH_DATA);
      else
         cur_ph = ph_ff;

      cur_byte   = '0;
      covered    = 1'b1;
      first      = 1'b0;
      phase_done = 1'b0;
      cmd_done   = 1'b0;
      next_ph    = cur_ph;
      unique case (cur_ph)
         PH_HDR: begin
            first      = (idx_ff == '0);
            phase_done = (idx_ff == IDX_W'(HDR_BYTES - 1));
            next_ph    = PH_TRL;
            unique case (idx_ff)
               4'd0:    cur_byte = MARK_HEADER;
               4'd1:    cur_byte = 8'h00;
               4'd2:    cur_byte = 8'hFF;
               4'd3:    cur_byte = cfg.load_mode;
               4'd4:    cur_byte = cfg.block_size[31:24];
               4'd5:    cur_byte = cfg.block_size[23:16];
               4'd6:    cur_byte = cfg.block_size[15:8];
               4'd7:    cur_byte = cfg.block_size[7:0];
               4'd8:    cur_byte = cfg.load_address[31:24];
               4'd9:    cur_byte = cfg.load_address[23:16];
               4'd10:   cur_byte = cfg.load_address[15:8];
               4'd11:   cur_byte = cfg.load_address[7:0];
               default: cur_byte = '0;
            endcase
         end
         PH_OPEN: begin
            first      = (idx_ff == '0);
            phase_done = (idx_ff == IDX_W'(OPEN_BYTES - 1));
            next_ph    = PH_DATA;
            unique case (idx_ff)
               4'd0:    cur_byte = MARK_DATA;
               4'd1:    cur_byte = cmd.seq;
               default: cur_byte = ~cmd.seq;
            endcase
         end
         PH_DATA: begin
            cur_byte   = cmd.data;
            phase_done = 1'b1;
            next_ph    = PH_TRL;
            cmd_done   = !cmd.close;
         end
         PH_TRL: begin
            covered    = 1'b0;
            cur_byte   = (idx_ff == '0) ? crc_ff[15:8] : crc_ff[7:0];
            phase_done = (idx_ff == IDX_W'(TRL_BYTES - 1));
            next_ph    = PH_END;
            cmd_done   = phase_done && !cmd.last;
         end
         PH_END: begin
            first      = (idx_ff == '0);
            phase_done = (idx_ff == IDX_W'(OPEN_BYTES - 1));
            next_ph    = PH_ETRL;
            unique case (idx_ff)
               4'd0:    cur_byte = MARK_END;
               4'd1:    cur_byte = end_seq;
               default: cur_byte = ~end_seq;
            endcase
         end
         PH_ETRL: begin
            covered    = 1'b0;
            cur_byte   = (idx_ff == '0) ? crc_ff[15:8] : crc_ff[7:0];
            phase_done = (idx_ff == IDX_W'(TRL_BYTES - 1));
            cmd_done   = phase_done;
         end
         default: begin
            cur_byte = '0;
         end
      endcase
   end

   // Next state of sequencer, CRC and response register
   always_comb begin
      ph_in    = ph_ff;
      idx_in   = idx_ff;
      crc_in   = crc_ff;
      valid_in = valid_ff && !rsp_ready;
      byte_in  = byte_ff;
      fe_in    = fe_ff;
      be_in    = be_ff;
      cmd_pop  = 1'b0;
      if (advance) begin
         valid_in = 1'b1;
         byte_in  = cur_byte;
         fe_in    = (cur_ph == PH_TRL || cur_ph == PH_ETRL) && phase_done;
         be_in    = (cur_ph == PH_ETRL) && phase_done;
         if (covered) crc_in = crc_byte(first ? '0 : crc_ff, cur_byte);
         if (cmd_done) begin
            cmd_pop = 1'b1;
            ph_in   = PH_NEW;
            idx_in  = '0;
         end else if (phase_done) begin
            ph_in  = next_ph;
            idx_in = '0;
         end else begin
            ph_in  = cur_ph;
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff    <= PH_NEW;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         ph_ff    <= ph_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      crc_ff  <= crc_in;
      byte_ff <= byte_in;
      fe_ff   <= fe_in;
      be_ff   <= be_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_frame_end = fe_ff;
   assign rsp_block_end = be_ff;

endmodule

// ===== sv/boot_download_packet_framer.sv =====
// Top level of the boot download packet framer: CSR block, front end,
// command queue and back end. Depends on bdpf_pkg, bdpf_if and the macros.
//
//   channel  direction  handshake          payload
//   req_ch   in         valid/ready        opcode, data_byte
//   rsp_ch   out        valid/ready        out_byte, frame_end, block_end
//   csr      in         APB, pready high   load_mode, block_size, load_address
//
// The back end sends one byte per cycle while it holds a command and the response
// channel is ready; a request yields 1 byte for a payload byte inside a frame, up to 11
// when it opens, closes and ends a frame, 14 or 19 for a start.
// The front end takes a request per cycle while the 4-entry command queue
// has room, so framing overhead is absorbed there and by the output register.
// Reset is synchronous; no clearing pass.
`include "boot_download_packet_framer_macros.svh"

module boot_download_packet_framer import bdpf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   bdpf_req_if.sink              req_ch,
   bdpf_rsp_if.source            rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [WORD_W-1:0]     pwdata,
   output logic [WORD_W-1:0]     prdata,
   output logic                  pready
);

   cfg_type cfg;
   cmd_type push_cmd, head_cmd;
   logic    cmd_push, cmd_full, cmd_pop, head_valid;

   // Configuration registers
   bdpf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Request classification
   bdpf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_opcode    (req_ch.opcode),
      .req_data_byte (req_ch.data_byte),
      .block_size    (cfg.block_size),
      .cmd_full      (cmd_full),
      .cmd_push      (cmd_push),
      .cmd           (push_cmd)
   );

   // Decoupling queue
   bdpf_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_cmd   (push_cmd),
      .pop        (cmd_pop),
      .full       (cmd_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // Byte generation
   bdpf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .cmd_valid     (head_valid),
      .cmd           (head_cmd),
      .cmd_pop       (cmd_pop),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_out_byte  (rsp_ch.out_byte),
      .rsp_frame_end (rsp_ch.frame_end),
      .rsp_block_end (rsp_ch.block_end)
   );

   // Checks
   `BDPF_ASSERT(a_push_not_full, clock, reset, cmd_push |-> !cmd_full, "push into full queue")
   `BDPF_ASSERT(a_block_end_frame, clock, reset, (rsp_ch.valid && rsp_ch.block_end) |-> rsp_ch.frame_end, "block end off a frame end")
   `BDPF_ASSERT(a_pop_has_head, clock, reset, cmd_pop |-> head_valid, "pop from empty queue")
   `BDPF_ASSERT_ALWAYS(a_reset_idle, clock, (!reset && $past(reset)) |-> !rsp_ch.valid, "response valid after reset")

endmodule
